// ===== rtl/tlscst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TLS connection state tracker package
// State codes, request and response types, transition tables and the
// lookup helpers shared by the tracker modules.
// ----------------------------------------------------------------------------
package tlscst_pkg;

  localparam int unsigned NUM_STATES = 35;
  localparam int unsigned STATE_W    = 6;

  localparam logic [STATE_W-1:0] ST_UNINIT          = 6'd0;
  localparam logic [STATE_W-1:0] ST_INIT            = 6'd1;
  localparam logic [STATE_W-1:0] ST_CONNECTING      = 6'd2;
  localparam logic [STATE_W-1:0] ST_TCP_CONN        = 6'd3;
  localparam logic [STATE_W-1:0] ST_C_HS_INIT       = 6'd4;
  localparam logic [STATE_W-1:0] ST_C_HELLO_SENT    = 6'd5;
  localparam logic [STATE_W-1:0] ST_S_HELLO_RCVD    = 6'd6;
  localparam logic [STATE_W-1:0] ST_C_CERT_REQ      = 6'd7;
  localparam logic [STATE_W-1:0] ST_C_CERT_SENT     = 6'd8;
  localparam logic [STATE_W-1:0] ST_C_KEY_EXCH      = 6'd9;
  localparam logic [STATE_W-1:0] ST_C_CCS           = 6'd10;
  localparam logic [STATE_W-1:0] ST_C_FINISHED      = 6'd11;
  localparam logic [STATE_W-1:0] ST_S_HS_INIT       = 6'd12;
  localparam logic [STATE_W-1:0] ST_C_HELLO_RCVD    = 6'd13;
  localparam logic [STATE_W-1:0] ST_S_HELLO_SENT    = 6'd14;
  localparam logic [STATE_W-1:0] ST_S_CERT_SENT     = 6'd15;
  localparam logic [STATE_W-1:0] ST_S_KEY_EXCH      = 6'd16;
  localparam logic [STATE_W-1:0] ST_S_CERT_REQ      = 6'd17;
  localparam logic [STATE_W-1:0] ST_S_HELLO_DONE    = 6'd18;
  localparam logic [STATE_W-1:0] ST_C_CERT_RCVD     = 6'd19;
  localparam logic [STATE_W-1:0] ST_S_CCS           = 6'd20;
  localparam logic [STATE_W-1:0] ST_S_FINISHED      = 6'd21;
  localparam logic [STATE_W-1:0] ST_WANT_READ       = 6'd22;
  localparam logic [STATE_W-1:0] ST_WANT_WRITE      = 6'd23;
  localparam logic [STATE_W-1:0] ST_WANT_ASYNC      = 6'd24;
  localparam logic [STATE_W-1:0] ST_CERT_VALIDATING = 6'd25;
  localparam logic [STATE_W-1:0] ST_CONNECTED       = 6'd26;
  localparam logic [STATE_W-1:0] ST_RENEG_REQ       = 6'd27;
  localparam logic [STATE_W-1:0] ST_RENEG_PROG      = 6'd28;
  localparam logic [STATE_W-1:0] ST_SHUT_INIT       = 6'd29;
  localparam logic [STATE_W-1:0] ST_SHUT_SENT       = 6'd30;
  localparam logic [STATE_W-1:0] ST_SHUT_RCVD       = 6'd31;
  localparam logic [STATE_W-1:0] ST_SHUT_DONE       = 6'd32;
  localparam logic [STATE_W-1:0] ST_CLOSED          = 6'd33;
  localparam logic [STATE_W-1:0] ST_ERROR           = 6'd34;
  localparam logic [STATE_W-1:0] ST_LAST            = ST_ERROR;
  localparam logic [STATE_W-1:0] NO_NEXT            = 6'd63;

  localparam logic [7:0] ERR_WANT_READ      = 8'd2;
  localparam logic [7:0] ERR_WANT_WRITE     = 8'd3;
  localparam logic [7:0] ERR_WANT_ASYNC     = 8'd4;
  localparam logic [7:0] ERR_WANT_ASYNC_JOB = 8'd7;
  localparam logic [7:0] ERR_WANT_HELLO_CB  = 8'd8;

  typedef enum logic [1:0] {
    OP_CHECKED = 2'd0,
    OP_FORCED  = 2'd1,
    OP_RESULT  = 2'd2,
    OP_READY   = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [STATE_W-1:0] target_state;
    logic              result_positive;
    logic [7:0]        error_code;
    logic              readable;
    logic              writable;
  } tlscst_req_t;

  typedef struct packed {
    logic               accepted;
    logic [STATE_W-1:0] prev_state;
    logic [STATE_W-1:0] next_state;
    logic               handshaking;
    logic               io_blocked;
    logic               data_allowed;
    logic               shutdown_allowed;
  } tlscst_rsp_t;

  typedef logic [NUM_STATES-1:0] row_t;

  function automatic row_t sb(logic [STATE_W-1:0] s);
    return row_t'(1) << s;
  endfunction

  localparam row_t CLIENT_TBL [NUM_STATES] = '{
    sb(ST_INIT) | sb(ST_ERROR),
    sb(ST_CONNECTING) | sb(ST_CLOSED) | sb(ST_ERROR),
    sb(ST_TCP_CONN) | sb(ST_CLOSED) | sb(ST_ERROR),
    sb(ST_C_HS_INIT) | sb(ST_CLOSED) | sb(ST_ERROR),
    sb(ST_C_HELLO_SENT) | sb(ST_WANT_WRITE) | sb(ST_WANT_READ) | sb(ST_ERROR),
    sb(ST_S_HELLO_RCVD) | sb(ST_WANT_READ) | sb(ST_ERROR),
    sb(ST_C_CERT_REQ) | sb(ST_C_KEY_EXCH) | sb(ST_CERT_VALIDATING) | sb(ST_WANT_READ)
      | sb(ST_ERROR),
    sb(ST_C_CERT_SENT) | sb(ST_C_KEY_EXCH) | sb(ST_WANT_ASYNC) | sb(ST_ERROR),
    sb(ST_C_KEY_EXCH) | sb(ST_WANT_WRITE) | sb(ST_ERROR),
    sb(ST_C_CCS) | sb(ST_WANT_WRITE) | sb(ST_ERROR),
    sb(ST_C_FINISHED) | sb(ST_WANT_WRITE) | sb(ST_ERROR),
    sb(ST_CONNECTED) | sb(ST_WANT_READ) | sb(ST_ERROR),
    '0, '0, '0, '0, '0, '0, '0, '0, '0, '0,
    sb(ST_C_HS_INIT) | sb(ST_C_HELLO_SENT) | sb(ST_S_HELLO_RCVD) | sb(ST_C_FINISHED)
      | sb(ST_CONNECTED) | sb(ST_ERROR),
    sb(ST_C_HS_INIT) | sb(ST_C_CERT_SENT) | sb(ST_C_KEY_EXCH) | sb(ST_C_CCS)
      | sb(ST_C_FINISHED) | sb(ST_ERROR),
    sb(ST_C_CERT_SENT) | sb(ST_C_KEY_EXCH) | sb(ST_ERROR),
    sb(ST_C_KEY_EXCH) | sb(ST_ERROR),
    sb(ST_RENEG_REQ) | sb(ST_SHUT_INIT) | sb(ST_SHUT_RCVD) | sb(ST_ERROR),
    sb(ST_RENEG_PROG) | sb(ST_CONNECTED) | sb(ST_ERROR),
    sb(ST_CONNECTED) | sb(ST_WANT_READ) | sb(ST_WANT_WRITE) | sb(ST_ERROR),
    sb(ST_SHUT_SENT) | sb(ST_CLOSED) | sb(ST_ERROR),
    sb(ST_SHUT_RCVD) | sb(ST_SHUT_DONE) | sb(ST_CLOSED) | sb(ST_ERROR),
    sb(ST_SHUT_SENT) | sb(ST_SHUT_DONE) | sb(ST_CLOSED) | sb(ST_ERROR),
    sb(ST_CLOSED),
    '0, '0
  };

  localparam row_t SERVER_TBL [NUM_STATES] = '{
    sb(ST_INIT) | sb(ST_ERROR),
    sb(ST_TCP_CONN) | sb(ST_CLOSED) | sb(ST_ERROR),
    '0,
    sb(ST_S_HS_INIT) | sb(ST_CLOSED) | sb(ST_ERROR),
    '0, '0, '0, '0, '0, '0, '0, '0,
    sb(ST_C_HELLO_RCVD) | sb(ST_WANT_READ) | sb(ST_ERROR),
    sb(ST_S_HELLO_SENT) | sb(ST_WANT_ASYNC) | sb(ST_ERROR),
    sb(ST_S_CERT_SENT) | sb(ST_WANT_WRITE) | sb(ST_ERROR),
    sb(ST_S_KEY_EXCH) | sb(ST_S_CERT_REQ) | sb(ST_S_HELLO_DONE) | sb(ST_WANT_WRITE)
      | sb(ST_ERROR),
    sb(ST_S_CERT_REQ) | sb(ST_S_HELLO_DONE) | sb(ST_WANT_WRITE) | sb(ST_ERROR),
    sb(ST_S_HELLO_DONE) | sb(ST_WANT_WRITE) | sb(ST_ERROR),
    sb(ST_C_CERT_RCVD) | sb(ST_S_CCS) | sb(ST_WANT_READ) | sb(ST_ERROR),
    sb(ST_CERT_VALIDATING) | sb(ST_S_CCS) | sb(ST_WANT_READ) | sb(ST_ERROR),
    sb(ST_S_FINISHED) | sb(ST_WANT_READ) | sb(ST_ERROR),
    sb(ST_CONNECTED) | sb(ST_WANT_WRITE) | sb(ST_ERROR),
    sb(ST_C_HELLO_RCVD) | sb(ST_C_CERT_RCVD) | sb(ST_S_CCS) | sb(ST_CONNECTED)
      | sb(ST_ERROR),
    sb(ST_S_HELLO_SENT) | sb(ST_S_CERT_SENT) | sb(ST_S_KEY_EXCH) | sb(ST_S_CERT_REQ)
      | sb(ST_S_HELLO_DONE) | sb(ST_S_FINISHED) | sb(ST_ERROR),
    sb(ST_S_HELLO_SENT) | sb(ST_ERROR),
    sb(ST_S_CCS) | sb(ST_ERROR),
    sb(ST_RENEG_REQ) | sb(ST_SHUT_INIT) | sb(ST_SHUT_RCVD) | sb(ST_ERROR),
    sb(ST_RENEG_PROG) | sb(ST_CONNECTED) | sb(ST_ERROR),
    sb(ST_CONNECTED) | sb(ST_WANT_READ) | sb(ST_WANT_WRITE) | sb(ST_ERROR),
    sb(ST_SHUT_SENT) | sb(ST_CLOSED) | sb(ST_ERROR),
    sb(ST_SHUT_RCVD) | sb(ST_SHUT_DONE) | sb(ST_CLOSED) | sb(ST_ERROR),
    sb(ST_SHUT_SENT) | sb(ST_SHUT_DONE) | sb(ST_CLOSED) | sb(ST_ERROR),
    sb(ST_CLOSED),
    '0, '0
  };

  function automatic logic move_allowed(logic server, logic [STATE_W-1:0] from,
                                        logic [STATE_W-1:0] to);
    row_t row;
    row = '0;
    if (from <= ST_LAST) begin
      row = server ? SERVER_TBL[from] : CLIENT_TBL[from];
    end
    return (to <= ST_LAST) && row[to];
  endfunction

  function automatic logic [STATE_W-1:0] next_handshake(logic server,
                                                        logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] nxt;
    nxt = NO_NEXT;
    if (server) begin
      unique case (s)
        ST_S_HS_INIT:    nxt = ST_C_HELLO_RCVD;
        ST_C_HELLO_RCVD: nxt = ST_S_HELLO_SENT;
        ST_S_HELLO_SENT: nxt = ST_S_CERT_SENT;
        ST_S_CERT_SENT:  nxt = ST_S_HELLO_DONE;
        ST_S_HELLO_DONE: nxt = ST_C_CERT_RCVD;
        ST_C_CERT_RCVD:  nxt = ST_S_CCS;
        ST_S_CCS:        nxt = ST_S_FINISHED;
        ST_S_FINISHED:   nxt = ST_CONNECTED;
        default:         nxt = NO_NEXT;
      endcase
    end else begin
      unique case (s)
        ST_C_HS_INIT:    nxt = ST_C_HELLO_SENT;
        ST_C_HELLO_SENT: nxt = ST_S_HELLO_RCVD;
        ST_S_HELLO_RCVD: nxt = ST_C_KEY_EXCH;
        ST_C_KEY_EXCH:   nxt = ST_C_CCS;
        ST_C_CCS:        nxt = ST_C_FINISHED;
        ST_C_FINISHED:   nxt = ST_CONNECTED;
        default:         nxt = NO_NEXT;
      endcase
    end
    return nxt;
  endfunction

  function automatic logic [STATE_W-1:0] error_target(logic [7:0] code);
    logic [STATE_W-1:0] t;
    unique case (code)
      ERR_WANT_READ:      t = ST_WANT_READ;
      ERR_WANT_WRITE:     t = ST_WANT_WRITE;
      ERR_WANT_ASYNC,
      ERR_WANT_ASYNC_JOB,
      ERR_WANT_HELLO_CB:  t = ST_WANT_ASYNC;
      default:            t = ST_ERROR;
    endcase
    return t;
  endfunction

  function automatic logic in_handshake(logic [STATE_W-1:0] s);
    return ((s >= ST_C_HS_INIT) && (s <= ST_CERT_VALIDATING)) || (s == ST_RENEG_PROG);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tlscst_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TLS connection state tracker: request evaluation
// Decodes one request against the current state and mode, checks the move
// against the transition table and forms the response with its status flags.
// ----------------------------------------------------------------------------
module tlscst_eval (
  input  wire logic                              server_mode_i,
  input  wire logic [tlscst_pkg::STATE_W-1:0]    state_i,
  input  wire tlscst_pkg::tlscst_req_t           req_i,
  output tlscst_pkg::tlscst_rsp_t                rsp_o
);

  logic [tlscst_pkg::STATE_W-1:0] hs_next;
  logic [tlscst_pkg::STATE_W-1:0] err_next;
  logic [tlscst_pkg::STATE_W-1:0] cand;
  logic [tlscst_pkg::STATE_W-1:0] state_nxt;
  logic                           want_check;
  logic                           forced;
  logic                           success;
  logic                           accepted;

  assign hs_next  = tlscst_pkg::next_handshake(server_mode_i, state_i);
  assign err_next = tlscst_pkg::error_target(req_i.error_code);

  always_comb begin
    cand       = req_i.target_state;
    want_check = 1'b0;
    forced     = 1'b0;
    success    = 1'b0;
    unique case (req_i.op)
      tlscst_pkg::OP_CHECKED: begin
        want_check = 1'b1;
      end
      tlscst_pkg::OP_FORCED: begin
        forced = (req_i.target_state <= tlscst_pkg::ST_LAST);
      end
      tlscst_pkg::OP_RESULT: begin
        if (req_i.result_positive) begin
          success = 1'b1;
        end else begin
          cand       = err_next;
          want_check = (err_next != state_i);
        end
      end
      tlscst_pkg::OP_READY: begin
        success = ((state_i == tlscst_pkg::ST_WANT_READ) && req_i.readable) ||
                  ((state_i == tlscst_pkg::ST_WANT_WRITE) && req_i.writable);
      end
      default: begin
        want_check = 1'b0;
      end
    endcase
    // success advances the handshake when a next step exists
    if (success) begin
      cand       = hs_next;
      want_check = tlscst_pkg::in_handshake(state_i) && (hs_next != tlscst_pkg::NO_NEXT);
    end
  end

  always_comb begin
    accepted  = forced ||
                (want_check && tlscst_pkg::move_allowed(server_mode_i, state_i, cand));
    state_nxt = accepted ? cand : state_i;
  end

  always_comb begin
    rsp_o.accepted         = accepted;
    rsp_o.prev_state       = state_i;
    rsp_o.next_state       = state_nxt;
    rsp_o.handshaking      = tlscst_pkg::in_handshake(state_nxt);
    rsp_o.io_blocked       = (state_nxt >= tlscst_pkg::ST_WANT_READ) &&
                             (state_nxt <= tlscst_pkg::ST_CERT_VALIDATING);
    rsp_o.data_allowed     = (state_nxt == tlscst_pkg::ST_CONNECTED);
    rsp_o.shutdown_allowed = (state_nxt == tlscst_pkg::ST_CONNECTED) ||
                             (state_nxt == tlscst_pkg::ST_SHUT_RCVD);
  end

endmodule
`default_nettype wire

// ===== rtl/tls_connection_state_tracker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TLS connection state tracker
// Tracks the state of one TLS connection with client and server transition
// tables; each request produces one response with the old and new state.
// ----------------------------------------------------------------------------
// path: a taken request waits in the request register, then evaluation
//   writes the response register once the response side can take it
// throughput: one request per cycle while the response side is not stalled, set by the single state register update
// reset: state returns to Uninitialized, mode to client, both stages empty
// ----------------------------------------------------------------------------
module tls_connection_state_tracker_top (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire tlscst_pkg::tlscst_req_t  in_req_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output tlscst_pkg::tlscst_rsp_t       out_rsp_o
);

  logic                           server_mode_q;
  logic [tlscst_pkg::STATE_W-1:0] conn_state_q;
  logic                           req_valid_q;
  tlscst_pkg::tlscst_req_t        req_q;
  logic                           rsp_valid_q;
  tlscst_pkg::tlscst_rsp_t        rsp_q;
  tlscst_pkg::tlscst_rsp_t        rsp_d;
  logic                           fire;

  tlscst_eval u_eval (
    .server_mode_i (server_mode_q),
    .state_i       (conn_state_q),
    .req_i         (req_q),
    .rsp_o         (rsp_d)
  );

  assign fire        = req_valid_q && (!rsp_valid_q || out_ready_i);
  assign in_ready_o  = !req_valid_q || fire;
  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_mode_q <= 1'b0;
      conn_state_q  <= tlscst_pkg::ST_UNINIT;
      req_valid_q   <= 1'b0;
      rsp_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        server_mode_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (fire) begin
        conn_state_q <= rsp_d.next_state;
        rsp_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conn_state_q <= tlscst_pkg::ST_LAST)
    else $error("connection state out of range");

  a_rsp_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (rsp_valid_q && (rsp_q.next_state == conn_state_q)))
    else $error("response new state differs from tracked state");

  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_q.accepted) |-> (rsp_q.next_state == rsp_q.prev_state))
    else $error("rejected request changed state");

  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && !fire) |=> (req_valid_q && $stable(req_q)))
    else $error("pending request lost");

endmodule
`default_nettype wire

// ===== dv/tls_connection_state_tracker_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS connection state tracker testbench
// Walks a short table of hand-picked requests in client mode, then runs
// random phases that switch between client and server tables. Each response
// is checked field by field against a local model of both transition tables,
// with random idle bursts on the request side and stalls on the response side.
// ----------------------------------------------------------------------------
module tls_connection_state_tracker_top_tb;
  import tlscst_pkg::*;

  localparam int DIRECTED_LEN = 24;
  localparam int NUM_PHASES   = 5;
  localparam int QUIET_LIMIT  = 1000;

  // one bit per phase: mode written before it, and whether idling is on
  localparam logic [NUM_PHASES-1:0] PHASE_MODE = 5'b10101;
  localparam logic [NUM_PHASES-1:0] PHASE_IDLE = 5'b01111;
  localparam int PHASE_LEN [NUM_PHASES] = '{300, 300, 300, 200, 150};

  typedef struct packed {
    tlscst_req_t req;
    logic        typed;
    tlscst_rsp_t rsp;
  } script_row_t;

  // typed rows carry their response, the rest go through the model
  localparam script_row_t SCRIPT [DIRECTED_LEN] = '{
    '{'{OP_RESULT, ST_UNINIT, 1'b1, 8'd0, 1'b0, 1'b0}, 1'b1,
      '{1'b0, ST_UNINIT, ST_UNINIT, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_CHECKED, 6'd63, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b1,
      '{1'b0, ST_UNINIT, ST_UNINIT, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_FORCED, 6'd63, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b1,
      '{1'b0, ST_UNINIT, ST_UNINIT, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_READY, ST_UNINIT, 1'b0, 8'd0, 1'b1, 1'b1}, 1'b1,
      '{1'b0, ST_UNINIT, ST_UNINIT, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_CHECKED, ST_INIT, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_CHECKED, ST_CONNECTING, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_FORCED, ST_C_HS_INIT, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_RESULT, ST_UNINIT, 1'b1, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_RESULT, ST_UNINIT, 1'b0, ERR_WANT_READ, 1'b0, 1'b0}, 1'b1,
      '{1'b1, ST_C_HELLO_SENT, ST_WANT_READ, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{'{OP_READY, ST_UNINIT, 1'b0, 8'd0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{OP_RESULT, ST_UNINIT, 1'b0, ERR_WANT_READ, 1'b0, 1'b0}, 1'b1,
      '{1'b0, ST_WANT_READ, ST_WANT_READ, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{'{OP_CHECKED, ST_CONNECTED, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_RESULT, ST_UNINIT, 1'b1, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_FORCED, ST_WANT_WRITE, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_READY, ST_UNINIT, 1'b0, 8'd0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{OP_READY, ST_UNINIT, 1'b0, 8'd0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{OP_RESULT, ST_UNINIT, 1'b0, ERR_WANT_ASYNC_JOB, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_RESULT, ST_UNINIT, 1'b0, 8'd255, 1'b0, 1'b0}, 1'b1,
      '{1'b1, ST_WANT_WRITE, ST_ERROR, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_RESULT, ST_UNINIT, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b1,
      '{1'b0, ST_ERROR, ST_ERROR, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_CHECKED, ST_UNINIT, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_FORCED, ST_ERROR, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b1,
      '{1'b1, ST_ERROR, ST_ERROR, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_FORCED, ST_SHUT_RCVD, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_RESULT, ST_UNINIT, 1'b0, ERR_WANT_ASYNC, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_FORCED, ST_UNINIT, 1'b0, 8'd0, 1'b0, 1'b0}, 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  tlscst_req_t in_req_i;
  logic        out_valid_o;
  logic        out_ready_i;
  tlscst_rsp_t out_rsp_o;

  logic [STATE_W-1:0] conn_model = ST_UNINIT;
  logic               server_model = 1'b0;
  tlscst_rsp_t        rsp_expected_q [$];
  logic               typed_now;
  tlscst_rsp_t        typed_rsp;
  logic               gaps_on;
  logic               stalls_on;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;

  tls_connection_state_tracker_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic row_t mask(logic [STATE_W-1:0] s);
    return row_t'(1) << s;
  endfunction

  function automatic row_t allowed_row(logic server, logic [STATE_W-1:0] s);
    row_t row;
    row = '0;
    case (s)
      ST_UNINIT:     row = mask(ST_INIT) | mask(ST_ERROR);
      ST_CONNECTED:  row = mask(ST_RENEG_REQ) | mask(ST_SHUT_INIT) | mask(ST_SHUT_RCVD)
                           | mask(ST_ERROR);
      ST_RENEG_REQ:  row = mask(ST_RENEG_PROG) | mask(ST_CONNECTED) | mask(ST_ERROR);
      ST_RENEG_PROG: row = mask(ST_CONNECTED) | mask(ST_WANT_READ) | mask(ST_WANT_WRITE)
                           | mask(ST_ERROR);
      ST_SHUT_INIT:  row = mask(ST_SHUT_SENT) | mask(ST_CLOSED) | mask(ST_ERROR);
      ST_SHUT_SENT:  row = mask(ST_SHUT_RCVD) | mask(ST_SHUT_DONE) | mask(ST_CLOSED)
                           | mask(ST_ERROR);
      ST_SHUT_RCVD:  row = mask(ST_SHUT_SENT) | mask(ST_SHUT_DONE) | mask(ST_CLOSED)
                           | mask(ST_ERROR);
      ST_SHUT_DONE:  row = mask(ST_CLOSED);
      default: begin
        if (server) begin
          case (s)
            ST_INIT:         row = mask(ST_TCP_CONN) | mask(ST_CLOSED) | mask(ST_ERROR);
            ST_TCP_CONN:     row = mask(ST_S_HS_INIT) | mask(ST_CLOSED) | mask(ST_ERROR);
            ST_S_HS_INIT:    row = mask(ST_C_HELLO_RCVD) | mask(ST_WANT_READ) | mask(ST_ERROR);
            ST_C_HELLO_RCVD: row = mask(ST_S_HELLO_SENT) | mask(ST_WANT_ASYNC)
                                   | mask(ST_ERROR);
            ST_S_HELLO_SENT: row = mask(ST_S_CERT_SENT) | mask(ST_WANT_WRITE) | mask(ST_ERROR);
            ST_S_CERT_SENT:  row = mask(ST_S_KEY_EXCH) | mask(ST_S_CERT_REQ)
                                   | mask(ST_S_HELLO_DONE) | mask(ST_WANT_WRITE)
                                   | mask(ST_ERROR);
            ST_S_KEY_EXCH:   row = mask(ST_S_CERT_REQ) | mask(ST_S_HELLO_DONE)
                                   | mask(ST_WANT_WRITE) | mask(ST_ERROR);
            ST_S_CERT_REQ:   row = mask(ST_S_HELLO_DONE) | mask(ST_WANT_WRITE)
                                   | mask(ST_ERROR);
            ST_S_HELLO_DONE: row = mask(ST_C_CERT_RCVD) | mask(ST_S_CCS) | mask(ST_WANT_READ)
                                   | mask(ST_ERROR);
            ST_C_CERT_RCVD:  row = mask(ST_CERT_VALIDATING) | mask(ST_S_CCS)
                                   | mask(ST_WANT_READ) | mask(ST_ERROR);
            ST_S_CCS:        row = mask(ST_S_FINISHED) | mask(ST_WANT_READ) | mask(ST_ERROR);
            ST_S_FINISHED:   row = mask(ST_CONNECTED) | mask(ST_WANT_WRITE) | mask(ST_ERROR);
            ST_WANT_READ:    row = mask(ST_C_HELLO_RCVD) | mask(ST_C_CERT_RCVD)
                                   | mask(ST_S_CCS) | mask(ST_CONNECTED) | mask(ST_ERROR);
            ST_WANT_WRITE:   row = mask(ST_S_HELLO_SENT) | mask(ST_S_CERT_SENT)
                                   | mask(ST_S_KEY_EXCH) | mask(ST_S_CERT_REQ)
                                   | mask(ST_S_HELLO_DONE) | mask(ST_S_FINISHED)
                                   | mask(ST_ERROR);
            ST_WANT_ASYNC:   row = mask(ST_S_HELLO_SENT) | mask(ST_ERROR);
            ST_CERT_VALIDATING: row = mask(ST_S_CCS) | mask(ST_ERROR);
            default:         row = '0;
          endcase
        end else begin
          case (s)
            ST_INIT:         row = mask(ST_CONNECTING) | mask(ST_CLOSED) | mask(ST_ERROR);
            ST_CONNECTING:   row = mask(ST_TCP_CONN) | mask(ST_CLOSED) | mask(ST_ERROR);
            ST_TCP_CONN:     row = mask(ST_C_HS_INIT) | mask(ST_CLOSED) | mask(ST_ERROR);
            ST_C_HS_INIT:    row = mask(ST_C_HELLO_SENT) | mask(ST_WANT_WRITE)
                                   | mask(ST_WANT_READ) | mask(ST_ERROR);
            ST_C_HELLO_SENT: row = mask(ST_S_HELLO_RCVD) | mask(ST_WANT_READ) | mask(ST_ERROR);
            ST_S_HELLO_RCVD: row = mask(ST_C_CERT_REQ) | mask(ST_C_KEY_EXCH)
                                   | mask(ST_CERT_VALIDATING) | mask(ST_WANT_READ)
                                   | mask(ST_ERROR);
            ST_C_CERT_REQ:   row = mask(ST_C_CERT_SENT) | mask(ST_C_KEY_EXCH)
                                   | mask(ST_WANT_ASYNC) | mask(ST_ERROR);
            ST_C_CERT_SENT:  row = mask(ST_C_KEY_EXCH) | mask(ST_WANT_WRITE) | mask(ST_ERROR);
            ST_C_KEY_EXCH:   row = mask(ST_C_CCS) | mask(ST_WANT_WRITE) | mask(ST_ERROR);
            ST_C_CCS:        row = mask(ST_C_FINISHED) | mask(ST_WANT_WRITE) | mask(ST_ERROR);
            ST_C_FINISHED:   row = mask(ST_CONNECTED) | mask(ST_WANT_READ) | mask(ST_ERROR);
            ST_WANT_READ:    row = mask(ST_C_HS_INIT) | mask(ST_C_HELLO_SENT)
                                   | mask(ST_S_HELLO_RCVD) | mask(ST_C_FINISHED)
                                   | mask(ST_CONNECTED) | mask(ST_ERROR);
            ST_WANT_WRITE:   row = mask(ST_C_HS_INIT) | mask(ST_C_CERT_SENT)
                                   | mask(ST_C_KEY_EXCH) | mask(ST_C_CCS)
                                   | mask(ST_C_FINISHED) | mask(ST_ERROR);
            ST_WANT_ASYNC:   row = mask(ST_C_CERT_SENT) | mask(ST_C_KEY_EXCH) | mask(ST_ERROR);
            ST_CERT_VALIDATING: row = mask(ST_C_KEY_EXCH) | mask(ST_ERROR);
            default:         row = '0;
          endcase
        end
      end
    endcase
    return row;
  endfunction

  // next step of the handshake on a successful call, NO_NEXT where there is none
  function automatic logic [STATE_W-1:0] success_step(logic server,
                                                      logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] nxt;
    nxt = NO_NEXT;
    if (server) begin
      case (s)
        ST_S_HS_INIT:    nxt = ST_C_HELLO_RCVD;
        ST_C_HELLO_RCVD: nxt = ST_S_HELLO_SENT;
        ST_S_HELLO_SENT: nxt = ST_S_CERT_SENT;
        ST_S_CERT_SENT:  nxt = ST_S_HELLO_DONE;
        ST_S_HELLO_DONE: nxt = ST_C_CERT_RCVD;
        ST_C_CERT_RCVD:  nxt = ST_S_CCS;
        ST_S_CCS:        nxt = ST_S_FINISHED;
        ST_S_FINISHED:   nxt = ST_CONNECTED;
        default:         nxt = NO_NEXT;
      endcase
    end else begin
      case (s)
        ST_C_HS_INIT:    nxt = ST_C_HELLO_SENT;
        ST_C_HELLO_SENT: nxt = ST_S_HELLO_RCVD;
        ST_S_HELLO_RCVD: nxt = ST_C_KEY_EXCH;
        ST_C_KEY_EXCH:   nxt = ST_C_CCS;
        ST_C_CCS:        nxt = ST_C_FINISHED;
        ST_C_FINISHED:   nxt = ST_CONNECTED;
        default:         nxt = NO_NEXT;
      endcase
    end
    return nxt;
  endfunction

  function automatic logic [STATE_W-1:0] error_landing(logic [7:0] code);
    case (code)
      ERR_WANT_READ:  return ST_WANT_READ;
      ERR_WANT_WRITE: return ST_WANT_WRITE;
      ERR_WANT_ASYNC, ERR_WANT_ASYNC_JOB, ERR_WANT_HELLO_CB: return ST_WANT_ASYNC;
      default:        return ST_ERROR;
    endcase
  endfunction

  // applies one request to the local connection state and builds its response
  function automatic tlscst_rsp_t advance_connection(tlscst_req_t r);
    tlscst_rsp_t        rsp;
    row_t               row;
    logic [STATE_W-1:0] prev;
    logic [STATE_W-1:0] goal;
    logic               took;
    prev = conn_model;
    goal = NO_NEXT;
    took = 1'b0;
    case (r.op)
      OP_CHECKED: goal = r.target_state;
      OP_FORCED: begin
        if (r.target_state <= ST_LAST) begin
          conn_model = r.target_state;
          took = 1'b1;
        end
      end
      OP_RESULT: begin
        if (r.result_positive) begin
          goal = success_step(server_model, prev);
        end else if (error_landing(r.error_code) != prev) begin
          goal = error_landing(r.error_code);
        end
      end
      default: begin
        if ((prev == ST_WANT_READ && r.readable) || (prev == ST_WANT_WRITE && r.writable)) begin
          goal = success_step(server_model, prev);
        end
      end
    endcase
    row = allowed_row(server_model, prev);
    if (goal <= ST_LAST && row[goal]) begin
      conn_model = goal;
      took = 1'b1;
    end
    rsp.accepted         = took;
    rsp.prev_state       = prev;
    rsp.next_state       = conn_model;
    rsp.handshaking      = (conn_model >= ST_C_HS_INIT && conn_model <= ST_CERT_VALIDATING)
                           || conn_model == ST_RENEG_PROG;
    rsp.io_blocked       = conn_model >= ST_WANT_READ && conn_model <= ST_CERT_VALIDATING;
    rsp.data_allowed     = conn_model == ST_CONNECTED;
    rsp.shutdown_allowed = conn_model == ST_CONNECTED || conn_model == ST_SHUT_RCVD;
    return rsp;
  endfunction

  // mostly handshake progress and legal moves, with forced jumps and noise
  function automatic tlscst_req_t pick_request();
    tlscst_req_t r;
    row_t        row;
    int          k;
    r.op              = OP_RESULT;
    r.target_state    = 6'($urandom);
    r.result_positive = 1'($urandom);
    r.error_code      = 8'($urandom);
    r.readable        = 1'($urandom);
    r.writable        = 1'($urandom);
    k = $urandom_range(0, 99);
    if (k < 35) begin
      r.result_positive = 1'b1;
    end else if (k < 55) begin
      r.op = OP_CHECKED;
      row = allowed_row(server_model, conn_model);
      if (row != '0) begin
        do r.target_state = 6'($urandom_range(0, NUM_STATES - 1));
        while (!row[r.target_state]);
      end
    end else if (k < 62) begin
      r.op = OP_CHECKED;
    end else if (k < 72) begin
      r.op = OP_FORCED;
      case ($urandom_range(0, 4))
        0: r.target_state = ST_TCP_CONN;
        1: r.target_state = server_model ? ST_S_HS_INIT : ST_C_HS_INIT;
        2: r.target_state = ST_CONNECTED;
        3: r.target_state = 6'($urandom_range(0, NUM_STATES - 1));
        default: ;
      endcase
    end else if (k < 86) begin
      r.result_positive = 1'b0;
      case ($urandom_range(0, 9))
        0: r.error_code = ERR_WANT_READ;
        1: r.error_code = ERR_WANT_WRITE;
        2: r.error_code = ERR_WANT_ASYNC;
        3: r.error_code = ERR_WANT_ASYNC_JOB;
        4: r.error_code = ERR_WANT_HELLO_CB;
        default: ;
      endcase
    end else begin
      r.op = OP_READY;
    end
    return r;
  endfunction

  // called at a falling edge, returns at the edge that takes the request
  task automatic send_request(tlscst_req_t r, logic typed, tlscst_rsp_t rsp);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      in_req_i.target_state = 6'($urandom);
      in_req_i.error_code   = 8'($urandom);
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_req_i   = r;
    typed_now  = typed;
    typed_rsp  = rsp;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_responses();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (rsp_expected_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_mode(logic server);
    drain_responses();
    cfg_wdata_i = server;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i     = 1'b0;
    server_model = server;
  endtask

  always begin
    @(negedge clk_i);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      out_ready_i = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    out_ready_i = 1'b1;
  end

  always @(posedge clk_i) begin : scoreboard
    tlscst_rsp_t want;
    tlscst_rsp_t got;
    tlscst_rsp_t predicted;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = advance_connection(in_req_i);
        if (typed_now) begin
          predicted = typed_rsp;
        end
        rsp_expected_q = {rsp_expected_q, predicted};
      end
      if (out_valid_o && out_ready_i) begin
        got = out_rsp_o;
        if (rsp_expected_q.size() == 0) begin
          $error("response with no request outstanding: %h", got);
          mismatches++;
        end else begin
          want = rsp_expected_q.pop_front();
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            mismatches++;
          end
          if (got.prev_state !== want.prev_state) begin
            $error("prev_state: expected %0d, got %0d", want.prev_state, got.prev_state);
            mismatches++;
          end
          if (got.next_state !== want.next_state) begin
            $error("next_state: expected %0d, got %0d", want.next_state, got.next_state);
            mismatches++;
          end
          if (got.handshaking !== want.handshaking) begin
            $error("handshaking: expected %0d, got %0d", want.handshaking, got.handshaking);
            mismatches++;
          end
          if (got.io_blocked !== want.io_blocked) begin
            $error("io_blocked: expected %0d, got %0d", want.io_blocked, got.io_blocked);
            mismatches++;
          end
          if (got.data_allowed !== want.data_allowed) begin
            $error("data_allowed: expected %0d, got %0d", want.data_allowed,
                   got.data_allowed);
            mismatches++;
          end
          if (got.shutdown_allowed !== want.shutdown_allowed) begin
            $error("shutdown_allowed: expected %0d, got %0d", want.shutdown_allowed,
                   got.shutdown_allowed);
            mismatches++;
          end
        end
      end
    end
  end

  // cycles in which neither side moves a request or response
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    typed_now   = 1'b0;
    typed_rsp   = '0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      @(negedge clk_i);
      send_request(SCRIPT[i].req, SCRIPT[i].typed, SCRIPT[i].rsp);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mode(PHASE_MODE[p]);
      gaps_on   = PHASE_IDLE[p];
      stalls_on = PHASE_IDLE[p];
      for (int i = 0; i < PHASE_LEN[p]; i++) begin
        if (PHASE_IDLE[p] && i == PHASE_LEN[p] / 2) drain_responses();
        @(negedge clk_i);
        send_request(pick_request(), 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (rsp_expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
